// ----- hdl/css_pkg.sv -----
// Shared types, constants and the byte fold function for the caseless substring search.
// Used by css_csr, css_match and caseless_substring_search. No dependencies.
package css_pkg;

   localparam int BYTE_W       = 8;
   localparam int PAT_BYTES    = 16;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_LEN_W    = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int RSP_OFFSET_W = 16;

   localparam logic [BYTE_W-1:0] LOWER_A   = 8'h61;
   localparam logic [BYTE_W-1:0] LOWER_Z   = 8'h7A;
   localparam logic [BYTE_W-1:0] CASE_DIFF = 8'h20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAT_LOW  = 2'd0,
      CSR_PAT_HIGH = 2'd1,
      CSR_PAT_LEN  = 2'd2
   } css_csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              end_of_text;
   } css_item_type;

   typedef struct packed {
      logic                    match_found;
      logic [RSP_OFFSET_W-1:0] match_offset;
   } css_result_type;

   function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
      if (b >= LOWER_A && b <= LOWER_Z) begin
         return b - CASE_DIFF;
      end
      return b;
   endfunction

endpackage

// ----- hdl/css_csr.sv -----
// Pattern registers and the registered, folded, length-aligned copy of the pattern.
// Depends on css_pkg.
module css_csr
   import css_pkg::*;
#(
   parameter int PATTERN_MAX = 16,
   localparam int PM_W  = $clog2(PATTERN_MAX + 1),
   localparam int LEN_W = (CSR_LEN_W > PM_W) ? CSR_LEN_W : PM_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic [BYTE_W-1:0]      aligned_byte [PATTERN_MAX],
   output logic [PATTERN_MAX-1:0] aligned_mask,
   output logic [LEN_W-1:0]       pat_len,
   output logic                   pat_empty
);

   logic [CSR_DATA_W-1:0]  pat_low_ff, pat_low_in;
   logic [CSR_DATA_W-1:0]  pat_high_ff, pat_high_in;
   logic [CSR_LEN_W-1:0]   pat_len_cfg_ff, pat_len_cfg_in;

   logic [BYTE_W-1:0]      aligned_ff [PATTERN_MAX];
   logic [BYTE_W-1:0]      aligned_in [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] mask_ff, mask_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic                   empty_ff, empty_in;

   logic [2*CSR_DATA_W-1:0] pat_all;
   logic [LEN_W-1:0]        len_clamped;

   assign csr_ready = 1'b1;

   always_comb begin
      pat_low_in     = pat_low_ff;
      pat_high_in    = pat_high_ff;
      pat_len_cfg_in = pat_len_cfg_ff;
      if (csr_valid) begin
         case (css_csr_index_type'(csr_index))
            CSR_PAT_LOW:  pat_low_in     = csr_data;
            CSR_PAT_HIGH: pat_high_in    = csr_data;
            CSR_PAT_LEN:  pat_len_cfg_in = csr_data[CSR_LEN_W-1:0];
            default:      ;
         endcase
      end
   end

   // Entry j of the window lines up with pattern byte len-1-j.
   always_comb begin
      pat_all     = {pat_high_ff, pat_low_ff};
      len_clamped = LEN_W'(pat_len_cfg_ff);
      if (len_clamped > LEN_W'(PATTERN_MAX)) begin
         len_clamped = LEN_W'(PATTERN_MAX);
      end
      for (int j = 0; j < PATTERN_MAX; j++) begin
         aligned_in[j] = '0;
         mask_in[j]    = (j < int'(len_clamped));
         for (int k = 0; k < PAT_BYTES; k++) begin
            if (j + k + 1 == int'(len_clamped)) begin
               aligned_in[j] = fold_byte(pat_all[k*BYTE_W +: BYTE_W]);
            end
         end
      end
      len_in   = len_clamped;
      empty_in = (len_clamped == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff     <= '0;
         pat_high_ff    <= '0;
         pat_len_cfg_ff <= '0;
         mask_ff        <= '0;
         len_ff         <= '0;
         empty_ff       <= 1'b1;
         for (int j = 0; j < PATTERN_MAX; j++) begin
            aligned_ff[j] <= '0;
         end
      end else begin
         pat_low_ff     <= pat_low_in;
         pat_high_ff    <= pat_high_in;
         pat_len_cfg_ff <= pat_len_cfg_in;
         mask_ff        <= mask_in;
         len_ff         <= len_in;
         empty_ff       <= empty_in;
         for (int j = 0; j < PATTERN_MAX; j++) begin
            aligned_ff[j] <= aligned_in[j];
         end
      end
   end

   assign aligned_byte = aligned_ff;
   assign aligned_mask = mask_ff;
   assign pat_len      = len_ff;
   assign pat_empty    = empty_ff;

endmodule

// ----- hdl/css_match.sv -----
// Input register, folded text window, parallel window compare and result register.
// Depends on css_pkg; takes the aligned pattern from css_csr.
module css_match
   import css_pkg::*;
#(
   parameter int PATTERN_MAX  = 16,
   parameter int OFFSET_WIDTH = 16,
   localparam int PM_W  = $clog2(PATTERN_MAX + 1),
   localparam int LEN_W = (CSR_LEN_W > PM_W) ? CSR_LEN_W : PM_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  css_item_type           req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output css_result_type         rsp_result,
   input  logic [BYTE_W-1:0]      aligned_byte [PATTERN_MAX],
   input  logic [PATTERN_MAX-1:0] aligned_mask,
   input  logic [LEN_W-1:0]       pat_len,
   input  logic                   pat_empty
);

   logic                    stage_valid_ff, stage_valid_in;
   css_item_type            stage_item_ff, stage_item_in;
   logic [BYTE_W-1:0]       window_ff [PATTERN_MAX];
   logic [BYTE_W-1:0]       window_in [PATTERN_MAX];
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;
   logic                    found_ff, found_in;
   logic [OFFSET_WIDTH-1:0] found_off_ff, found_off_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   css_result_type          rsp_ff, rsp_in;

   logic                    fire;
   logic                    all_equal;
   logic                    hit;
   logic [OFFSET_WIDTH-1:0] pos_next;
   logic [OFFSET_WIDTH-1:0] len_ext;

   // Process the staged byte unless its result would overrun a held response.
   assign fire      = stage_valid_ff &&
                      (!stage_item_ff.end_of_text || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || fire;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_item_in  = stage_item_ff;
      if (req_valid && req_ready) begin
         stage_valid_in          = 1'b1;
         stage_item_in.text_byte   = fold_byte(req_item.text_byte);
         stage_item_in.end_of_text = req_item.end_of_text;
      end else if (fire) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      window_in[0] = stage_item_ff.text_byte;
      for (int j = 1; j < PATTERN_MAX; j++) begin
         window_in[j] = window_ff[j-1];
      end

      all_equal = 1'b1;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (aligned_mask[j] && window_in[j] != aligned_byte[j]) begin
            all_equal = 1'b0;
         end
      end

      pos_next = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
      len_ext  = OFFSET_WIDTH'(pat_len);
      hit      = !found_ff && (pat_empty || (pos_next >= len_ext && all_equal));

      pos_in       = pos_ff;
      found_in     = found_ff;
      found_off_in = found_off_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (fire) begin
         pos_in = pos_next;
         if (hit) begin
            found_in     = 1'b1;
            found_off_in = pat_empty ? '0 : pos_next - len_ext;
         end
         if (stage_item_ff.end_of_text) begin
            rsp_valid_in         = 1'b1;
            rsp_in.match_found   = found_in;
            rsp_in.match_offset  = found_in ? RSP_OFFSET_W'(found_off_in) : '0;
            // Start the next haystack from scratch.
            pos_in       = '0;
            found_in     = 1'b0;
            found_off_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         pos_ff         <= '0;
         found_ff       <= 1'b0;
         found_off_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         pos_ff         <= pos_in;
         found_ff       <= found_in;
         found_off_ff   <= found_off_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
      rsp_ff        <= rsp_in;
      if (fire) begin
         for (int j = 0; j < PATTERN_MAX; j++) begin
            window_ff[j] <= window_in[j];
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

// ----- hdl/caseless_substring_search.sv -----
// Top level of the caseless substring search: config registers plus match datapath.
// Depends on css_pkg, css_csr and css_match.
//
//   channel  | direction | handshake              | payload
//   req_     | in        | req_valid / req_ready  | req_text_byte, req_end_of_text
//   rsp_     | out       | rsp_valid / rsp_ready  | rsp_match_found, rsp_match_offset
//   csr_     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// One text byte per cycle unless a last byte waits; a byte sits in the input register
// while its compare against the whole window runs, and the compare of the last byte
// loads the response register. The response register holds while rsp_ready is low;
// bytes not marked last still flow, and a last byte waits in the input register.
// Reset clears the pattern, the position counter and the match state.
// Pattern writes take effect for bytes accepted from the next cycle on.
module caseless_substring_search
   import css_pkg::*;
#(
   parameter int PATTERN_MAX  = 16,
   parameter int OFFSET_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [BYTE_W-1:0]       req_text_byte,
   input  logic                    req_end_of_text,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_match_found,
   output logic [RSP_OFFSET_W-1:0] rsp_match_offset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int PM_W  = $clog2(PATTERN_MAX + 1);
   localparam int LEN_W = (CSR_LEN_W > PM_W) ? CSR_LEN_W : PM_W;

   logic [BYTE_W-1:0]      aligned_byte [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] aligned_mask;
   logic [LEN_W-1:0]       pat_len;
   logic                   pat_empty;
   css_item_type           req_item;
   css_result_type         rsp_result;

   assign req_item.text_byte   = req_text_byte;
   assign req_item.end_of_text = req_end_of_text;

   css_csr #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .aligned_byte (aligned_byte),
      .aligned_mask (aligned_mask),
      .pat_len      (pat_len),
      .pat_empty    (pat_empty)
   );

   css_match #(
      .PATTERN_MAX  (PATTERN_MAX),
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_match (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_result   (rsp_result),
      .aligned_byte (aligned_byte),
      .aligned_mask (aligned_mask),
      .pat_len      (pat_len),
      .pat_empty    (pat_empty)
   );

   assign rsp_match_found  = rsp_result.match_found;
   assign rsp_match_offset = rsp_result.match_offset;

endmodule

// ----- verif/css_search_checker.sv -----
// Scoreboard for the caseless substring search: watches the request, response and
// register channels, predicts each search outcome and compares it. Depends on css_pkg.
module css_search_checker
   import css_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [BYTE_W-1:0]       req_text_byte,
   input  logic                    req_end_of_text,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_match_found,
   input  logic [RSP_OFFSET_W-1:0] rsp_match_offset,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   output int                      fail_count,
   output int                      results_pending
);

   logic [CSR_DATA_W-1:0]   pat_low;
   logic [CSR_DATA_W-1:0]   pat_high;
   logic [CSR_LEN_W-1:0]    pat_len;
   logic [BYTE_W-1:0]       history [PAT_BYTES];
   logic [RSP_OFFSET_W-1:0] text_pos;
   logic                    hit_seen;
   logic [RSP_OFFSET_W-1:0] hit_pos;
   css_result_type          outcome_q [$];

   function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] c);
      if (c >= "a" && c <= "z") begin
         return c - ("a" - "A");
      end
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_char(input int idx);
      if (idx < 8) begin
         return pat_low[BYTE_W*idx +: BYTE_W];
      end
      return pat_high[BYTE_W*(idx-8) +: BYTE_W];
   endfunction

   task automatic report_error(input string msg);
      $display("[%0t] search mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic clear_text();
      for (int i = 0; i < PAT_BYTES; i++) begin
         history[i] = '0;
      end
      text_pos = '0;
      hit_seen = 1'b0;
      hit_pos  = '0;
   endtask

   task automatic take_text(input logic [BYTE_W-1:0] c, input logic eot);
      int             span;
      bit             hit;
      css_result_type outcome;
      span = (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
      for (int i = PAT_BYTES - 1; i > 0; i--) begin
         history[i] = history[i-1];
      end
      history[0] = upcase(c);
      // saturate the position at the top of its range
      if (text_pos != '1) begin
         text_pos++;
      end
      if (!hit_seen) begin
         if (span == 0) begin
            hit_seen = 1'b1;
            hit_pos  = '0;
         end else if (text_pos >= span) begin
            hit = 1'b1;
            for (int i = 0; i < span; i++) begin
               if (upcase(pattern_char(i)) != history[span-1-i]) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               hit_seen = 1'b1;
               hit_pos  = text_pos - RSP_OFFSET_W'(span);
            end
         end
      end
      if (eot) begin
         outcome.match_found  = hit_seen;
         outcome.match_offset = hit_seen ? hit_pos : '0;
         outcome_q.push_back(outcome);
         clear_text();
      end
   endtask

   task automatic check_result();
      css_result_type want;
      if (outcome_q.size() == 0) begin
         report_error($sformatf("response with nothing expected: found %0b offset %0d",
                                rsp_match_found, rsp_match_offset));
      end else begin
         want = outcome_q.pop_front();
         if (rsp_match_found !== want.match_found) begin
            report_error($sformatf("match_found got %0b want %0b",
                                   rsp_match_found, want.match_found));
         end
         if (rsp_match_offset !== want.match_offset) begin
            report_error($sformatf("match_offset got %0d want %0d",
                                   rsp_match_offset, want.match_offset));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pat_low  = '0;
         pat_high = '0;
         pat_len  = '0;
         clear_text();
         outcome_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (req_valid && req_ready) begin
            take_text(req_text_byte, req_end_of_text);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PAT_LOW:  pat_low  = csr_data;
               CSR_PAT_HIGH: pat_high = csr_data;
               CSR_PAT_LEN:  pat_len  = csr_data[CSR_LEN_W-1:0];
               default: ;
            endcase
         end
      end
      results_pending <= outcome_q.size();
   end

endmodule

// ----- verif/caseless_substring_search_tb.sv -----
// Top of the caseless substring search testbench: clock, reset, request and register
// stimulus, response back-pressure and the verdict. Depends on css_pkg, css_search_checker
// and the caseless_substring_search block.
module caseless_substring_search_tb;
   import css_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT   = 1000;
   localparam int PHASES        = 8;
   localparam int PHASE_TEXT    = 95;
   localparam int LONG_TEXT     = 40;

   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic [BYTE_W-1:0]       req_text_byte   = '0;
   logic                    req_end_of_text = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b0;
   logic                    rsp_match_found;
   logic [RSP_OFFSET_W-1:0] rsp_match_offset;
   logic                    csr_valid       = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index       = CSR_PAT_LOW;
   logic [CSR_DATA_W-1:0]   csr_data        = '0;

   int                      fail_count;
   int                      results_pending;
   int                      quiet_cycles;
   bit                      sender_gaps;
   bit                      receiver_stalls;
   logic [BYTE_W-1:0]       needle [PAT_BYTES];
   int                      needle_span;
   logic [BYTE_W-1:0]       hay [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   caseless_substring_search DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_match_found  (rsp_match_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   css_search_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_match_found  (rsp_match_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .results_pending  (results_pending)
   );

   // Flip the case of a letter half of the time; other bytes pass unchanged.
   function automatic logic [BYTE_W-1:0] mix_case(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] up;
      up = c & ~8'h20;
      if (up >= "A" && up <= "Z" && $urandom_range(0, 1) == 1) begin
         return c ^ 8'h20;
      end
      return c;
   endfunction

   task automatic send_char(input logic [BYTE_W-1:0] c, input logic eot);
      int gap;
      gap = 0;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= c;
      req_end_of_text <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop the request, wait for every outstanding response, then let the pipeline empty.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input css_csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_pattern(input logic [CSR_DATA_W-1:0] lo, hi, input int span);
      settle();
      csr_write(CSR_PAT_LOW, lo);
      csr_write(CSR_PAT_HIGH, hi);
      csr_write(CSR_PAT_LEN, CSR_DATA_W'(span));
      for (int i = 0; i < PAT_BYTES; i++) begin
         needle[i] = (i < 8) ? lo[BYTE_W*i +: BYTE_W] : hi[BYTE_W*(i-8) +: BYTE_W];
      end
      needle_span = (span > PAT_BYTES) ? PAT_BYTES : span;
   endtask

   // Random back-pressure bursts on the response side.
   initial begin
      forever begin
         @(negedge clock);
         if (receiver_stalls && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [CSR_DATA_W-1:0] word_lo;
      logic [CSR_DATA_W-1:0] word_hi;
      logic [BYTE_W-1:0]     pick;
      int                    span_cfg;
      int                    hay_len;
      int                    at;
      int                    r;
      int                    sent;
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      needle_span     = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty pattern straight out of reset, zero text byte
      send_char(8'h00, 1'b1);

      // letter fold edges: the bytes just outside a-z must not fold
      load_pattern(64'h417A, '0, 2);
      send_char(8'h7B, 1'b0);
      send_char(8'h60, 1'b0);
      send_char("Z", 1'b0);
      send_char("a", 1'b1);

      // oversized length clamps to the full pattern, all-ones bytes
      load_pattern('1, '1, (1 << CSR_LEN_W) - 1);
      for (int i = 0; i < PAT_BYTES; i++) begin
         send_char(8'hFF, i == PAT_BYTES - 1);
      end

      // zero pattern bytes compare exactly
      load_pattern('0, '0, 3);
      send_char(8'h00, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'h00, 1'b1);

      // pattern change in the middle of a haystack keeps the earlier window
      load_pattern(64'h4241, '0, 2);
      send_char("x", 1'b0);
      send_char("a", 1'b0);
      load_pattern(64'h424158, '0, 3);
      send_char("b", 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         sender_gaps     = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
         receiver_stalls = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
         case (phase)
            0:       span_cfg = 1;
            1:       span_cfg = PAT_BYTES;
            2:       span_cfg = (1 << CSR_LEN_W) - 1;
            3:       span_cfg = 0;
            4:       span_cfg = $urandom_range(PAT_BYTES + 1, (1 << CSR_LEN_W) - 2);
            5:       span_cfg = $urandom_range(2, 4);
            default: span_cfg = $urandom_range(1, PAT_BYTES);
         endcase
         for (int i = 0; i < PAT_BYTES; i++) begin
            case ($urandom_range(0, 7))
               0:       pick = 8'($urandom_range(0, 255));
               1:       pick = 8'h00;
               default: pick = mix_case(8'("A" + $urandom_range(0, 25)));
            endcase
            if (i < 8) begin
               word_lo[BYTE_W*i +: BYTE_W] = pick;
            end else begin
               word_hi[BYTE_W*(i-8) +: BYTE_W] = pick;
            end
         end
         if (phase == PHASES - 2) begin
            word_lo = {$urandom, $urandom};
            word_hi = {$urandom, $urandom};
         end
         load_pattern(word_lo, word_hi, span_cfg);

         sent = 0;
         while (sent < PHASE_TEXT) begin
            hay_len = ($urandom_range(0, 4) == 0) ? $urandom_range(21, 70)
                                                  : $urandom_range(1, 20);
            hay.delete();
            for (int i = 0; i < hay_len; i++) begin
               r = $urandom_range(0, 9);
               if (needle_span > 0 && r < 5) begin
                  pick = mix_case(needle[$urandom_range(0, needle_span - 1)]);
               end else if (r < 8) begin
                  pick = mix_case(8'("A" + $urandom_range(0, 25)));
               end else begin
                  pick = 8'($urandom_range(0, 255));
               end
               hay.push_back(pick);
            end
            if (needle_span > 0 && hay_len >= needle_span && $urandom_range(0, 9) < 6) begin
               at = $urandom_range(0, hay_len - needle_span);
               for (int i = 0; i < needle_span; i++) begin
                  hay[at+i] = mix_case(needle[i]);
               end
               // spoil one byte now and then for a near miss
               if ($urandom_range(0, 4) == 0) begin
                  r = at + $urandom_range(0, needle_span - 1);
                  hay[r] = hay[r] + 8'd1;
               end
            end
            for (int i = 0; i < hay_len; i++) begin
               send_char(hay[i], i == hay_len - 1);
            end
            sent += hay_len;
            if ($urandom_range(0, 15) == 0) begin
               settle();
            end
         end
      end

      // longer haystack of non-letters, then place the match at the very end
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      load_pattern(64'h21746173, '0, 4);
      for (int i = 0; i < LONG_TEXT; i++) begin
         send_char(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
      end
      send_char("S", 1'b0);
      send_char("A", 1'b0);
      send_char("T", 1'b0);
      send_char("!", 1'b1);

      settle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/css_pkg.sv
hdl/css_csr.sv
hdl/css_match.sv
hdl/caseless_substring_search.sv
verif/css_search_checker.sv
verif/caseless_substring_search_tb.sv
